// ----- rtl/core/iir_filter_direct_form_one_unit_defines.svh -----
// Assertion macros for the direct-form-I IIR filter unit.
`ifndef IIR_FILTER_DIRECT_FORM_ONE_UNIT_DEFINES_SVH
`define IIR_FILTER_DIRECT_FORM_ONE_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define IIRDF1_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("iir filter check failed");

// Next-cycle implication, checked out of reset.
`define IIRDF1_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("iir filter check failed");

`endif

// ----- rtl/core/iirdf1_pkg.sv -----
// Types, constants and register indexes shared by the IIR filter files.
package iirdf1_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int COEF_EXT_W = COEF_W + 1;
  localparam int PROD_W     = SAMPLE_W + COEF_EXT_W;
  localparam int ACC_W      = PROD_W + 5;
  localparam int FRAC_BITS  = 12;
  localparam int ROUND_HALF = 2048;

  localparam int FEED_TAPS_DEF = 4;
  localparam int BACK_TAPS_DEF = 4;

  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = $clog2(NUM_REGS);

  typedef logic signed [SAMPLE_W-1:0]   sample_t;
  typedef logic signed [COEF_W-1:0]     coef_t;
  typedef logic signed [COEF_EXT_W-1:0] coef_ext_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [ACC_W-1:0]      acc_t;
  typedef logic [REG_IDX_W-1:0]         reg_idx_t;

  // Register map: feedforward b0..b3, then feedback a1..a4.
  localparam reg_idx_t REG_FEED0 = 3'd0;
  localparam reg_idx_t REG_BACK1 = 3'd4;

  localparam coef_t FEED0_RESET = 16'sd4096;

  typedef struct packed {
    sample_t sample;
    logic    sat;
  } result_t;

endpackage

// ----- rtl/core/iir_filter_direct_form_one_unit.sv -----
// Direct-form-I IIR filter unit: coefficient registers, tap cell chain, output buffer.
//
// Input channel (in_valid/in_ready/in_sample_in): one signed Q1.15 sample per
// transaction. Output channel (out_valid/out_ready): one filtered sample and a
// saturation flag per input transaction, in order.
// Configuration: write cfg_data into coefficient cfg_index while cfg_wr_en is
// high; indexes 0..3 are b0..b3, 4..7 are a1..a4, all Q4.12. Write only idle.
// Each accepted sample's result is registered into the output register if it
// is empty or being read, else into the skid register. Throughput: one sample
// per cycle while in_ready is high. The whole filter equation, from the output
// history register through the multiply-add cell chain, rounding and saturation
// back into that register, is combinational; that loop sets the clock.
// Stall: a two-entry output buffer lets one more sample in while a result
// waits; with both entries full in_ready drops until out_ready frees one.
// Reset: clears both sample histories, empties the output buffer and loads
// b0 = 1.0 with all other coefficients zero.
`include "iir_filter_direct_form_one_unit_defines.svh"

module iir_filter_direct_form_one_unit #(
  parameter int FEED_TAPS = iirdf1_pkg::FEED_TAPS_DEF,
  parameter int BACK_TAPS = iirdf1_pkg::BACK_TAPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  iirdf1_pkg::sample_t  in_sample_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output iirdf1_pkg::sample_t  out_sample_out,
  output logic                 out_saturated,
  input  logic                 cfg_wr_en,
  input  iirdf1_pkg::reg_idx_t cfg_index,
  input  iirdf1_pkg::coef_t    cfg_data
);
  import iirdf1_pkg::*;

  coef_t   coef_r   [NUM_REGS];
  coef_t   coef_nxt [NUM_REGS];
  logic    accept;
  prod_t   b0_prod;
  acc_t    feed_psum [FEED_TAPS];
  sample_t feed_hist [FEED_TAPS-1];
  acc_t    back_psum [BACK_TAPS+1];
  sample_t back_hist [BACK_TAPS];
  result_t y_new;
  result_t out_data;

  assign accept = in_valid & in_ready;

  // Coefficient registers; hold unless written.
  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) begin
      coef_nxt[i] = coef_r[i];
    end
    if (cfg_wr_en) begin
      coef_nxt[cfg_index] = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        coef_r[i] <= (i == int'(REG_FEED0)) ? FEED0_RESET : '0;
      end
    end else begin
      for (int i = 0; i < NUM_REGS; i++) begin
        coef_r[i] <= coef_nxt[i];
      end
    end
  end

  // Current sample term starts the running sum.
  assign b0_prod      = coef_ext_t'(coef_r[REG_FEED0]) * in_sample_in;
  assign feed_psum[0] = acc_t'(b0_prod);

  // Feedforward cells: advance the input history on every transaction.
  for (genvar k = 0; k < FEED_TAPS - 1; k++) begin : g_feed
    iirdf1_tap_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .advance  (accept),
      .hist_in  ((k == 0) ? in_sample_in : feed_hist[(k == 0) ? 0 : k - 1]),
      .coef     (coef_ext_t'(coef_r[int'(REG_FEED0) + 1 + k])),
      .psum_in  (feed_psum[k]),
      .hist_out (feed_hist[k]),
      .psum_out (feed_psum[k+1])
    );
  end

  assign back_psum[0] = feed_psum[FEED_TAPS-1];

  // Feedback cells: negated coefficients, fed by the saturated output.
  for (genvar k = 0; k < BACK_TAPS; k++) begin : g_back
    iirdf1_tap_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .advance  (accept),
      .hist_in  ((k == 0) ? y_new.sample : back_hist[(k == 0) ? 0 : k - 1]),
      .coef     (-coef_ext_t'(coef_r[int'(REG_BACK1) + k])),
      .psum_in  (back_psum[k]),
      .hist_out (back_hist[k]),
      .psum_out (back_psum[k+1])
    );
  end

  iirdf1_quant u_quant (
    .acc (back_psum[BACK_TAPS]),
    .res (y_new)
  );

  iirdf1_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (y_new),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_sample_out = out_data.sample;
  assign out_saturated  = out_data.sat;

  // A flagged result sits at one of the two rails.
  `IIRDF1_ASSERT_NOW(a_sat_at_rail, out_valid && out_saturated, (out_sample_out == 16'sh7fff || out_sample_out == 16'sh8000))
  // An accepted sample always leaves a result pending next cycle.
  `IIRDF1_ASSERT_NEXT(a_result_pending, accept, out_valid)
  // The newest output history entry is the value just computed.
  `IIRDF1_ASSERT_NEXT(a_hist_update, accept, back_hist[0] == $past(y_new.sample))

endmodule

// ----- rtl/core/iirdf1_tap_cell.sv -----
// One tap cell: holds a history sample, weights it and adds to the running sum.
module iirdf1_tap_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  iirdf1_pkg::sample_t   hist_in,
  input  iirdf1_pkg::coef_ext_t coef,
  input  iirdf1_pkg::acc_t      psum_in,
  output iirdf1_pkg::sample_t   hist_out,
  output iirdf1_pkg::acc_t      psum_out
);
  import iirdf1_pkg::*;

  sample_t hist_r;
  sample_t hist_nxt;
  prod_t   prod;

  always_comb begin
    hist_nxt = advance ? hist_in : hist_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
    end else begin
      hist_r <= hist_nxt;
    end
  end

  assign prod     = coef * hist_r;
  assign psum_out = psum_in + acc_t'(prod);
  assign hist_out = hist_r;

endmodule

// ----- rtl/core/iirdf1_quant.sv -----
// Round the Q11.27 sum to Q1.15 and saturate to 16 bits.
module iirdf1_quant (
  input  iirdf1_pkg::acc_t    acc,
  output iirdf1_pkg::result_t res
);
  import iirdf1_pkg::*;

  localparam int QW = ACC_W - FRAC_BITS;

  acc_t               rnd;
  logic signed [QW-1:0] q;
  logic               in_range;

  always_comb begin
    rnd      = acc + acc_t'(ROUND_HALF);
    q        = rnd[ACC_W-1:FRAC_BITS];
    // in range when all bits above the sample's sign bit match it
    in_range = (&q[QW-1:SAMPLE_W-1]) | ~(|q[QW-1:SAMPLE_W-1]);
    res.sat  = ~in_range;
    if (in_range) begin
      res.sample = q[SAMPLE_W-1:0];
    end else if (q[QW-1]) begin
      res.sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      res.sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

endmodule

// ----- rtl/core/iirdf1_out_buf.sv -----
// Two-entry output buffer: output register plus skid register.
module iirdf1_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  iirdf1_pkg::result_t push_data,
  output logic                can_push,
  output logic                out_valid,
  input  logic                out_ready,
  output iirdf1_pkg::result_t out_data
);
  import iirdf1_pkg::*;

  logic    out_vld_r, out_vld_nxt;
  logic    skid_vld_r, skid_vld_nxt;
  result_t out_r, out_nxt;
  result_t skid_r, skid_nxt;
  logic    load;

  assign can_push  = ~skid_vld_r;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_comb begin
    load         = ~out_vld_r | out_ready;
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    out_nxt      = out_r;
    skid_nxt     = skid_r;
    if (load) begin
      if (skid_vld_r) begin
        out_nxt      = skid_r;
        out_vld_nxt  = 1'b1;
        skid_vld_nxt = 1'b0;
      end else if (push) begin
        out_nxt     = push_data;
        out_vld_nxt = 1'b1;
      end else begin
        out_vld_nxt = 1'b0;
      end
    end else if (push) begin
      skid_nxt     = push_data;
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

endmodule
